### sv/psq_pkg.sv
// Shared types and constants for the power-down sequencer.
package psq_pkg;

  localparam int unsigned REG_WIDTH = 16;
  localparam int unsigned CFG_INDEX_WIDTH = 2;

  localparam logic [REG_WIDTH-1:0] RUN_TIME_RESET  = 16'd1;
  localparam logic [REG_WIDTH-1:0] EXIT_RUN_RESET  = 16'd0;
  localparam logic [REG_WIDTH-1:0] PREPARE_RESET   = 16'd0;
  localparam logic [REG_WIDTH-1:0] WAKE_TIME_RESET = 16'd15;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_RUN_TIME  = 2'd0,
    CFG_EXIT_RUN  = 2'd1,
    CFG_PREPARE   = 2'd2,
    CFG_WAKE_TIME = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_START     = 2'd1,
    OP_START_MIN = 2'd2,
    OP_RESUME    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_RUN  = 3'd1,
    ST_EXIT = 3'd2,
    ST_PREP = 3'd3,
    ST_GOTO = 3'd4
  } seq_state_t;

  typedef enum logic [1:0] {
    PH_INIT = 2'd0,
    PH_RUN  = 2'd1,
    PH_PREP = 2'd2,
    PH_WAIT = 2'd3
  } phase_t;

  typedef struct packed {
    logic exit_run_ready;
    logic prepare_ready;
    logic power_down_ready;
    logic continue_ready;
  } ready_flags_t;

endpackage

### sv/psq_step.sv
// Next-state logic of the sequencer for one request.
module psq_step #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  psq_pkg::op_t                     op,
  input  logic [psq_pkg::REG_WIDTH-1:0]    min_run_ticks,
  input  psq_pkg::ready_flags_t            flags,
  input  psq_pkg::seq_state_t              seq_state,
  input  psq_pkg::phase_t                  phase,
  input  logic [TIMER_WIDTH-1:0]           run_count,
  input  logic [TIMER_WIDTH-1:0]           exit_count,
  input  logic [TIMER_WIDTH-1:0]           prepare_count,
  input  logic [psq_pkg::REG_WIDTH-1:0]    run_time_reload,
  input  logic [psq_pkg::REG_WIDTH-1:0]    exit_run_reload,
  input  logic [psq_pkg::REG_WIDTH-1:0]    prepare_reload,
  output psq_pkg::seq_state_t              seq_state_nxt,
  output psq_pkg::phase_t                  phase_nxt,
  output logic [TIMER_WIDTH-1:0]           run_count_nxt,
  output logic [TIMER_WIDTH-1:0]           exit_count_nxt,
  output logic [TIMER_WIDTH-1:0]           prepare_count_nxt,
  output logic                             standby
);
  import psq_pkg::*;

  logic [TIMER_WIDTH-1:0] run_load;
  logic [TIMER_WIDTH-1:0] exit_load;
  logic [TIMER_WIDTH-1:0] prep_load;
  logic [TIMER_WIDTH-1:0] min_ticks;
  logic                   may_start;
  logic                   reach_goto;

  assign run_load  = TIMER_WIDTH'(run_time_reload);
  assign exit_load = TIMER_WIDTH'(exit_run_reload);
  assign prep_load = TIMER_WIDTH'(prepare_reload);
  assign min_ticks = TIMER_WIDTH'(min_run_ticks);
  assign may_start = (seq_state == ST_IDLE) || (seq_state == ST_RUN) || (seq_state == ST_EXIT);

  always_comb begin
    seq_state_nxt     = seq_state;
    phase_nxt         = phase;
    run_count_nxt     = run_count;
    exit_count_nxt    = exit_count;
    prepare_count_nxt = prepare_count;
    standby           = 1'b0;
    reach_goto        = 1'b0;
    case (op)
      OP_START: begin
        if (may_start) begin
          run_count_nxt = run_load;
          seq_state_nxt = ST_RUN;
        end
      end
      OP_START_MIN: begin
        if (may_start) begin
          if (run_count < min_ticks) begin
            run_count_nxt = min_ticks;
          end
          seq_state_nxt = ST_RUN;
        end
      end
      OP_RESUME: begin
        if (flags.continue_ready) begin
          run_count_nxt = run_load;
          seq_state_nxt = ST_RUN;
        end
      end
      default: begin
        case (seq_state)
          ST_RUN: begin
            phase_nxt = PH_RUN;
            if (run_count != '0) begin
              run_count_nxt = run_count - 1'b1;
            end else if (flags.exit_run_ready) begin
              seq_state_nxt  = ST_EXIT;
              exit_count_nxt = exit_load;
            end
          end
          ST_EXIT: begin
            if (exit_count != '0) begin
              exit_count_nxt = exit_count - 1'b1;
            end else begin
              phase_nxt = PH_PREP;
              if (flags.prepare_ready) begin
                seq_state_nxt     = ST_PREP;
                prepare_count_nxt = prep_load;
              end
            end
          end
          ST_PREP: begin
            if (prepare_count != '0) begin
              prepare_count_nxt = prepare_count - 1'b1;
            end else begin
              phase_nxt = PH_WAIT;
              if (flags.power_down_ready) begin
                reach_goto = 1'b1;
              end
            end
          end
          ST_GOTO: begin
            reach_goto = 1'b1;
          end
          default: begin
          end
        endcase
        // The goto phase requests standby on the same tick it is entered.
        if (reach_goto) begin
          standby = 1'b1;
          if (flags.continue_ready) begin
            seq_state_nxt = ST_RUN;
            run_count_nxt = run_load;
          end else begin
            seq_state_nxt = ST_GOTO;
          end
        end
      end
    endcase
  end

endmodule

### sv/power_down_sequencer.sv
// Top level of the event-driven power-down sequencer.
//
// Requests arrive on the in_ channel (valid/ready): an op code (tick, start,
// start with minimum run time, resume after wakeup), a minimum run time and
// four ready flags from the system. Each request yields exactly one result on
// the out_ channel: the sequencer state, the coarse system phase, a standby
// request flag and the wake time that goes with it.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata; the user must write them only while no request is in flight,
// as the block does not enforce this. A request is captured in an input
// register, then processed in one pass of logic into the result register,
// which raises out_valid when it is loaded. One request is accepted in every
// cycle while the receiver does not stall; the rate is bounded only by the
// single state update per cycle. If the receiver stalls, the result stays in
// the output register and one more request waits in the input register;
// in_ready then drops. Synchronous reset loads the register defaults,
// idles the sequencer and empties both registers.
module power_down_sequencer #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            in_op,
  input  logic [psq_pkg::REG_WIDTH-1:0]         in_min_run_ticks,
  input  logic                                  in_exit_run_ready,
  input  logic                                  in_prepare_ready,
  input  logic                                  in_power_down_ready,
  input  logic                                  in_continue_ready,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            out_sequencer_state,
  output logic [1:0]                            out_system_phase,
  output logic                                  out_enter_standby,
  output logic [psq_pkg::REG_WIDTH-1:0]         out_standby_wake_time,
  input  logic                                  cfg_we,
  input  logic [psq_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [psq_pkg::REG_WIDTH-1:0]         cfg_wdata
);
  import psq_pkg::*;

  logic [REG_WIDTH-1:0]   run_time_reload_r;
  logic [REG_WIDTH-1:0]   exit_run_reload_r;
  logic [REG_WIDTH-1:0]   prepare_reload_r;
  logic [REG_WIDTH-1:0]   wake_time_r;

  logic                   in_vld_r;
  logic [1:0]             in_op_r;
  logic [REG_WIDTH-1:0]   in_min_r;
  ready_flags_t           in_flags_r;

  seq_state_t             seq_state_r;
  phase_t                 phase_r;
  logic [TIMER_WIDTH-1:0] run_count_r;
  logic [TIMER_WIDTH-1:0] exit_count_r;
  logic [TIMER_WIDTH-1:0] prepare_count_r;

  seq_state_t             seq_state_nxt;
  phase_t                 phase_nxt;
  logic [TIMER_WIDTH-1:0] run_count_nxt;
  logic [TIMER_WIDTH-1:0] exit_count_nxt;
  logic [TIMER_WIDTH-1:0] prepare_count_nxt;
  logic                   standby;

  logic                   out_vld_r;
  logic [2:0]             out_state_r;
  logic [1:0]             out_phase_r;
  logic                   out_standby_r;
  logic [REG_WIDTH-1:0]   out_wake_r;

  logic                   fire;
  logic                   in_take;

  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_time_reload_r <= RUN_TIME_RESET;
      exit_run_reload_r <= EXIT_RUN_RESET;
      prepare_reload_r  <= PREPARE_RESET;
      wake_time_r       <= WAKE_TIME_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_RUN_TIME:  run_time_reload_r <= cfg_wdata;
        CFG_EXIT_RUN:  exit_run_reload_r <= cfg_wdata;
        CFG_PREPARE:   prepare_reload_r  <= cfg_wdata;
        CFG_WAKE_TIME: wake_time_r       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_take) begin
      in_op_r    <= in_op;
      in_min_r   <= in_min_run_ticks;
      in_flags_r <= '{exit_run_ready:   in_exit_run_ready,
                      prepare_ready:    in_prepare_ready,
                      power_down_ready: in_power_down_ready,
                      continue_ready:   in_continue_ready};
    end
  end

  psq_step #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_step (
    .op                (op_t'(in_op_r)),
    .min_run_ticks     (in_min_r),
    .flags             (in_flags_r),
    .seq_state         (seq_state_r),
    .phase             (phase_r),
    .run_count         (run_count_r),
    .exit_count        (exit_count_r),
    .prepare_count     (prepare_count_r),
    .run_time_reload   (run_time_reload_r),
    .exit_run_reload   (exit_run_reload_r),
    .prepare_reload    (prepare_reload_r),
    .seq_state_nxt     (seq_state_nxt),
    .phase_nxt         (phase_nxt),
    .run_count_nxt     (run_count_nxt),
    .exit_count_nxt    (exit_count_nxt),
    .prepare_count_nxt (prepare_count_nxt),
    .standby           (standby)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_state_r     <= ST_IDLE;
      phase_r         <= PH_INIT;
      run_count_r     <= TIMER_WIDTH'(RUN_TIME_RESET);
      exit_count_r    <= '0;
      prepare_count_r <= '0;
      out_vld_r       <= 1'b0;
    end else begin
      if (fire) begin
        seq_state_r     <= seq_state_nxt;
        phase_r         <= phase_nxt;
        run_count_r     <= run_count_nxt;
        exit_count_r    <= exit_count_nxt;
        prepare_count_r <= prepare_count_nxt;
        out_vld_r       <= 1'b1;
      end else if (out_ready) begin
        out_vld_r       <= 1'b0;
      end
    end
    if (fire) begin
      out_state_r   <= seq_state_nxt;
      out_phase_r   <= phase_nxt;
      out_standby_r <= standby;
      out_wake_r    <= standby ? wake_time_r : '0;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_sequencer_state   = out_state_r;
  assign out_system_phase      = out_phase_r;
  assign out_enter_standby     = out_standby_r;
  assign out_standby_wake_time = out_wake_r;

  a_goto_phase_wait: assert property (@(posedge clk) disable iff (!rst_n)
    seq_state_r == ST_GOTO |-> phase_r == PH_WAIT)
    else $error("Goto state reached without the waiting phase.");

  a_standby_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_enter_standby |->
      (out_sequencer_state == ST_GOTO || out_sequencer_state == ST_RUN))
    else $error("Standby requested outside goto or restarted run.");

  a_wake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_enter_standby |-> out_standby_wake_time == '0)
    else $error("Wake time reported without a standby request.");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && !out_ready |=> $stable(seq_state_r) && $stable(run_count_r))
    else $error("Sequencer state moved while the result was stalled.");

endmodule
